@@ design/dbts_pkg.sv @@
`default_nettype none

package dbts_pkg;

  // window depth and coordinate width
  localparam int MAX_HISTORY = 16;
  localparam int COORD_BITS  = 12;
  localparam int CNT_W       = $clog2(MAX_HISTORY + 1);

  // configuration port
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam int CFG_W  = 5;

  localparam logic [CFG_W-1:0] HIST_RESET    = 5'd5;
  localparam logic [CFG_W-1:0] MIN_DET_RESET = 5'd3;

  // register index, taken from paddr[2]
  localparam logic REG_HISTORY = 1'b0;
  localparam logic REG_MIN_DET = 1'b1;

  // sequencer states
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SETTLE = 2'd1;
  localparam logic [1:0] ST_DIVIDE = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

endpackage

`default_nettype wire

@@ design/dbts_if.sv @@
`default_nettype none

interface dbts_in_if import dbts_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic                  found;
  logic [COORD_BITS-1:0] box_left;
  logic [COORD_BITS-1:0] box_top;
  logic [COORD_BITS-1:0] box_width;
  logic [COORD_BITS-1:0] box_height;

  modport source (
    output valid, found, box_left, box_top, box_width, box_height,
    input  ready
  );
  modport sink (
    input  valid, found, box_left, box_top, box_width, box_height,
    output ready
  );
endinterface

interface dbts_out_if import dbts_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic                  show;
  logic [COORD_BITS-1:0] avg_left;
  logic [COORD_BITS-1:0] avg_top;
  logic [COORD_BITS-1:0] avg_width;
  logic [COORD_BITS-1:0] avg_height;
  logic [CNT_W-1:0]      detect_count;

  modport source (
    output valid, show, avg_left, avg_top, avg_width, avg_height, detect_count,
    input  ready
  );
  modport sink (
    input  valid, show, avg_left, avg_top, avg_width, avg_height, detect_count,
    output ready
  );
endinterface

`default_nettype wire

@@ design/dbts_cell.sv @@
`default_nettype none

module dbts_cell #(
  parameter int COORD_BITS = 12,
  parameter int CNT_W      = 5,
  parameter int SUM_W      = 18,
  parameter int IDX        = 0
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  shift,
  input  logic [CNT_W-1:0]      held,
  // box from the younger neighbor
  input  logic                  in_vld,
  input  logic [COORD_BITS-1:0] in_left,
  input  logic [COORD_BITS-1:0] in_top,
  input  logic [COORD_BITS:0]   in_right,
  input  logic [COORD_BITS:0]   in_bottom,
  // box toward the older neighbor
  output logic                  out_vld,
  output logic [COORD_BITS-1:0] out_left,
  output logic [COORD_BITS-1:0] out_top,
  output logic [COORD_BITS:0]   out_right,
  output logic [COORD_BITS:0]   out_bottom,
  // running window sums
  input  logic [CNT_W-1:0]      cnt_in,
  input  logic [SUM_W-1:0]      sl_in,
  input  logic [SUM_W-1:0]      st_in,
  input  logic [SUM_W-1:0]      sr_in,
  input  logic [SUM_W-1:0]      sb_in,
  output logic [CNT_W-1:0]      cnt_out,
  output logic [SUM_W-1:0]      sl_out,
  output logic [SUM_W-1:0]      st_out,
  output logic [SUM_W-1:0]      sr_out,
  output logic [SUM_W-1:0]      sb_out
);

  logic                  vld;
  logic [COORD_BITS-1:0] left;
  logic [COORD_BITS-1:0] top;
  logic [COORD_BITS:0]   right;
  logic [COORD_BITS:0]   bottom;
  logic                  take;

  // only the newest held frames count
  assign take = vld && (32'(held) > IDX);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (shift) begin
      vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      left   <= in_left;
      top    <= in_top;
      right  <= in_right;
      bottom <= in_bottom;
    end
  end

  always_ff @(posedge clk) begin
    cnt_out <= cnt_in + CNT_W'(take);
    sl_out  <= sl_in + (take ? SUM_W'(left)   : '0);
    st_out  <= st_in + (take ? SUM_W'(top)    : '0);
    sr_out  <= sr_in + (take ? SUM_W'(right)  : '0);
    sb_out  <= sb_in + (take ? SUM_W'(bottom) : '0);
  end

  assign out_vld    = vld;
  assign out_left   = left;
  assign out_top    = top;
  assign out_right  = right;
  assign out_bottom = bottom;

endmodule

`default_nettype wire

@@ design/dbts_div.sv @@
`default_nettype none

module dbts_div #(
  parameter int NUM_W = 18,
  parameter int DEN_W = 5
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quo,
  output logic             done
);

  localparam int STEP_W = $clog2(NUM_W + 1);

  logic              running;
  logic [STEP_W-1:0] step;
  logic [DEN_W-1:0]  rem;
  logic [DEN_W-1:0]  dvs;
  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    diff;
  logic              ge;

  // restoring division, one quotient bit per cycle
  assign trial = {rem, quo[NUM_W-1]};
  assign ge    = trial >= {1'b0, dvs};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        step    <= '0;
      end else if (running) begin
        step <= step + STEP_W'(1);
        if (step == STEP_W'(NUM_W - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= num;
      rem <= '0;
      dvs <= den;
    end else if (running) begin
      rem <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo <= {quo[NUM_W-2:0], ge};
    end
  end

endmodule

`default_nettype wire

@@ design/detection_box_temporal_smoother.sv @@
// a result word follows each accepted word once the cell chain sums have settled and the
// bit-per-cycle dividers have finished; one word is worked on at a time, so a new word is
// taken only after the result of the last is registered, which waits until the sink has
// taken any earlier result
// reset: window empty, history_length 5, min_detections 3, no result pending
`default_nettype none

module detection_box_temporal_smoother import dbts_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  dbts_in_if.sink           det,
  dbts_out_if.source        box,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int SUM_W = COORD_BITS + 1 + CNT_W;
  localparam logic [SUM_W-1:0] COORD_MAX = SUM_W'((64'd1 << COORD_BITS) - 64'd1);

  // configuration
  logic [CFG_W-1:0] hist_len;
  logic [CFG_W-1:0] min_det;
  logic             cfg_wr;

  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MIN_DET) ? DATA_W'(min_det) : DATA_W'(hist_len);

  always_ff @(posedge clk) begin
    if (rst) begin
      hist_len <= HIST_RESET;
      min_det  <= MIN_DET_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_HISTORY: hist_len <= pwdata[CFG_W-1:0];
        REG_MIN_DET: min_det  <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  logic [1:0]       state;
  logic [1:0]       state_next;
  logic [CNT_W-1:0] settle_cnt;
  logic             in_fire;
  logic             settle_done;
  logic             div_start;
  logic             out_load;
  logic [3:0]       div_done;

  assign in_fire     = det.valid && det.ready;
  assign det.ready   = (state == ST_IDLE);
  assign settle_done = (settle_cnt == CNT_W'(MAX_HISTORY));
  assign div_start   = (state == ST_SETTLE) && settle_done;
  assign out_load    = (state == ST_FINISH) && (!box.valid || box.ready);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_fire) state_next = ST_SETTLE;
      ST_SETTLE: if (settle_done) state_next = ST_DIVIDE;
      ST_DIVIDE: if (div_done[0]) state_next = ST_FINISH;
      ST_FINISH: if (out_load) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      settle_cnt <= '0;
    end else begin
      state <= state_next;
      if (in_fire) begin
        settle_cnt <= '0;
      end else if (state == ST_SETTLE && !settle_done) begin
        settle_cnt <= settle_cnt + CNT_W'(1);
      end
    end
  end

  // frames held in the window
  logic [CNT_W-1:0] held;
  logic [CNT_W-1:0] limit;
  logic [CNT_W:0]   held_inc;
  logic [CNT_W-1:0] held_next;

  assign limit     = (32'(hist_len) > MAX_HISTORY) ? CNT_W'(MAX_HISTORY) : CNT_W'(hist_len);
  assign held_inc  = {1'b0, held} + (CNT_W + 1)'(1);
  assign held_next = (held_inc > {1'b0, limit}) ? limit : held_inc[CNT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
    end else if (in_fire) begin
      held <= held_next;
    end
  end

  // cell chain: cell k holds the k-th newest frame
  logic                  vld_ch    [0:MAX_HISTORY];
  logic [COORD_BITS-1:0] left_ch   [0:MAX_HISTORY];
  logic [COORD_BITS-1:0] top_ch    [0:MAX_HISTORY];
  logic [COORD_BITS:0]   right_ch  [0:MAX_HISTORY];
  logic [COORD_BITS:0]   bottom_ch [0:MAX_HISTORY];
  logic [CNT_W-1:0]      cnt_ch    [0:MAX_HISTORY];
  logic [SUM_W-1:0]      sl_ch     [0:MAX_HISTORY];
  logic [SUM_W-1:0]      st_ch     [0:MAX_HISTORY];
  logic [SUM_W-1:0]      sr_ch     [0:MAX_HISTORY];
  logic [SUM_W-1:0]      sb_ch     [0:MAX_HISTORY];

  // zero-size or missing boxes enter as empty slots
  assign vld_ch[0]    = det.found && (det.box_width != '0) && (det.box_height != '0);
  assign left_ch[0]   = det.box_left;
  assign top_ch[0]    = det.box_top;
  assign right_ch[0]  = {1'b0, det.box_left} + {1'b0, det.box_width};
  assign bottom_ch[0] = {1'b0, det.box_top} + {1'b0, det.box_height};
  assign cnt_ch[0]    = '0;
  assign sl_ch[0]     = '0;
  assign st_ch[0]     = '0;
  assign sr_ch[0]     = '0;
  assign sb_ch[0]     = '0;

  for (genvar k = 0; k < MAX_HISTORY; k++) begin : g_cell
    dbts_cell #(
      .COORD_BITS (COORD_BITS),
      .CNT_W      (CNT_W),
      .SUM_W      (SUM_W),
      .IDX        (k)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .shift      (in_fire),
      .held       (held),
      .in_vld     (vld_ch[k]),
      .in_left    (left_ch[k]),
      .in_top     (top_ch[k]),
      .in_right   (right_ch[k]),
      .in_bottom  (bottom_ch[k]),
      .out_vld    (vld_ch[k+1]),
      .out_left   (left_ch[k+1]),
      .out_top    (top_ch[k+1]),
      .out_right  (right_ch[k+1]),
      .out_bottom (bottom_ch[k+1]),
      .cnt_in     (cnt_ch[k]),
      .sl_in      (sl_ch[k]),
      .st_in      (st_ch[k]),
      .sr_in      (sr_ch[k]),
      .sb_in      (sb_ch[k]),
      .cnt_out    (cnt_ch[k+1]),
      .sl_out     (sl_ch[k+1]),
      .st_out     (st_ch[k+1]),
      .sr_out     (sr_ch[k+1]),
      .sb_out     (sb_ch[k+1])
    );
  end

  logic [CNT_W-1:0] cnt_final;
  logic [SUM_W-1:0] sum_in [4];
  logic [SUM_W-1:0] quo    [4];

  assign cnt_final = cnt_ch[MAX_HISTORY];
  assign sum_in[0] = sl_ch[MAX_HISTORY];
  assign sum_in[1] = st_ch[MAX_HISTORY];
  assign sum_in[2] = sr_ch[MAX_HISTORY];
  assign sum_in[3] = sb_ch[MAX_HISTORY];

  // one divider per edge sum, all in lock step
  for (genvar d = 0; d < 4; d++) begin : g_div
    dbts_div #(
      .NUM_W (SUM_W),
      .DEN_W (CNT_W)
    ) u_div (
      .clk   (clk),
      .rst   (rst),
      .start (div_start),
      .num   (sum_in[d]),
      .den   (cnt_final),
      .quo   (quo[d]),
      .done  (div_done[d])
    );
  end

  // result
  logic             report;
  logic [SUM_W-1:0] dw;
  logic [SUM_W-1:0] dh;

  assign dw     = quo[2] - quo[0];
  assign dh     = quo[3] - quo[1];
  assign report = (32'(cnt_final) >= 32'(min_det)) && (cnt_final != '0)
                  && (quo[2] > quo[0]) && (quo[3] > quo[1]);

  logic                  ovalid;
  logic                  oshow;
  logic [COORD_BITS-1:0] oleft;
  logic [COORD_BITS-1:0] otop;
  logic [COORD_BITS-1:0] owidth;
  logic [COORD_BITS-1:0] oheight;
  logic [CNT_W-1:0]      ocount;

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (out_load) begin
      ovalid <= 1'b1;
    end else if (box.ready) begin
      ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      oshow   <= report;
      ocount  <= cnt_final;
      oleft   <= report ? quo[0][COORD_BITS-1:0] : '0;
      otop    <= report ? quo[1][COORD_BITS-1:0] : '0;
      owidth  <= !report ? '0 : (dw > COORD_MAX) ? COORD_MAX[COORD_BITS-1:0]
                                                 : dw[COORD_BITS-1:0];
      oheight <= !report ? '0 : (dh > COORD_MAX) ? COORD_MAX[COORD_BITS-1:0]
                                                 : dh[COORD_BITS-1:0];
    end
  end

  assign box.valid        = ovalid;
  assign box.show         = oshow;
  assign box.avg_left     = oleft;
  assign box.avg_top      = otop;
  assign box.avg_width    = owidth;
  assign box.avg_height   = oheight;
  assign box.detect_count = ocount;

  a_accept_settles: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> (state == ST_SETTLE) && (settle_cnt == '0))
    else $error("accepted word did not start the settle phase");

  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    32'(held) <= MAX_HISTORY)
    else $error("frames held exceeds window depth");

  a_div_in_phase: assert property (@(posedge clk) disable iff (rst)
    div_done[0] |-> (state == ST_DIVIDE) && (div_done == 4'b1111))
    else $error("divider finished outside the divide phase");

  a_count_in_window: assert property (@(posedge clk) disable iff (rst)
    out_load |-> cnt_final <= held)
    else $error("detection count exceeds frames held");

endmodule

`default_nettype wire
